// File: rtl/mpmlm_pkg.sv
`default_nettype none

package mpmlm_pkg;

    // Default sizes of the polled system.
    localparam int IO_SLAVES_DEF   = 2;
    localparam int ATS_WORDS_DEF   = 8;
    localparam int IO_BYTES_DEF    = 4;
    localparam int FRAME_BYTES_DEF = 19;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Input operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Modbus function codes.
    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FUNC_READ_INPUTS  = 8'h02;

    // Configuration register indexes.
    localparam logic [2:0] REG_ATS_ENABLE  = 3'd0;
    localparam logic [2:0] REG_IO_ENABLE   = 3'd1;
    localparam logic [2:0] REG_MODULE_CNT  = 3'd2;
    localparam logic [2:0] REG_ATS_ADDRESS = 3'd3;
    localparam logic [2:0] REG_IO_BASE     = 3'd4;
    localparam logic [2:0] REG_MISS_LIMIT  = 3'd5;
    localparam logic [2:0] REG_POLL_PERIOD = 3'd6;

    typedef struct packed {
        logic       ats_enable;
        logic       io_enable;
        logic [1:0] module_count;
        logic [7:0] ats_address;
        logic [7:0] io_base_address;
        logic [3:0] miss_limit;
        logic [7:0] poll_period;
    } cfg_t;

    // One unit of work for the back end: a poll of one slave or an accepted frame.
    typedef struct packed {
        logic       is_frame;
        logic       is_ats;
        logic       report;
        logic       last;
        logic [1:0] ch;
        logic [7:0] addr;
    } cmd_t;

    // One byte of CRC-16/MODBUS (reflected polynomial 0xA001).
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mpmlm_queue.sv
`default_nettype none

module mpmlm_queue #(
    parameter int DEPTH = 4
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  mpmlm_pkg::cmd_t     din,
    output logic                full,
    input  wire                 pop,
    output mpmlm_pkg::cmd_t     dout,
    output logic                not_empty
);
    import mpmlm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t            store_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign dout      = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mpmlm_front.sv
`default_nettype none

module mpmlm_front #(
    parameter int IO_SLAVES   = 2,
    parameter int FRAME_BYTES = 19
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mpmlm_pkg::cfg_t     cfg,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,
    input  wire  [2:0]          s_tuser,
    input  wire                 s_tlast,
    output logic                push,
    output mpmlm_pkg::cmd_t     cmd,
    input  wire                 full,
    input  wire                 frame_done,
    output logic [7:0]          frame [FRAME_BYTES]
);
    import mpmlm_pkg::*;

    localparam int SW = $clog2(IO_SLAVES + 1);
    localparam int NS = 2 ** SW;
    localparam int PW = $clog2(FRAME_BYTES + 1);
    localparam int FI = $clog2(FRAME_BYTES);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_POLL = 2'b10
    } fstate_t;

    fstate_t        state_reg, state_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [SW-1:0]  end_reg, end_next;
    logic [7:0]     phase_reg, phase_next;
    logic           waiting_reg [NS];
    logic           waiting_next [NS];
    logic [3:0]     miss_reg [NS];
    logic [3:0]     miss_next [NS];
    logic           faulted_reg [NS];
    logic           faulted_next [NS];
    logic [7:0]     frame_reg [FRAME_BYTES];
    logic [PW-1:0]  pos_reg, pos_next;
    logic [1:0]     rxch_reg, rxch_next;
    logic           busy_reg, busy_next;

    logic           acc;
    logic           op;
    logic [1:0]     in_ch;
    logic [1:0]     ch_f;
    logic [1:0]     s_f;
    logic [7:0]     byte0;
    logic [3:0]     used;
    logic [SW-1:0]  sidx;
    logic           fvalid;
    logic [7:0]     period;
    logic [8:0]     phase_inc;
    logic           has_io;
    logic           frame_wr;

    assign op     = s_tuser[0];
    assign in_ch  = s_tuser[2:1];
    assign acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == F_IDLE) && !full && !busy_reg;

    assign used   = ({2'b00, cfg.module_count} > 4'(IO_SLAVES)) ? 4'(IO_SLAVES)
                                                                  : {2'b00, cfg.module_count};
    assign has_io = cfg.io_enable && (used != '0);
    assign period = (cfg.poll_period == '0) ? 8'd1 : cfg.poll_period;
    assign phase_inc = {1'b0, phase_reg} + 9'd1;

    assign ch_f  = (pos_reg == '0) ? in_ch : rxch_reg;
    assign s_f   = ch_f - 2'd1;
    assign byte0 = (pos_reg == '0) ? s_tdata : frame_reg[0];
    assign sidx  = (state_reg == F_POLL) ? slot_reg : SW'(ch_f);

    always_comb
    begin
        if (ch_f == 2'd0)
        begin
            fvalid = cfg.ats_enable && waiting_reg[sidx] && (byte0 == cfg.ats_address);
        end
        else
        begin
            fvalid = ({2'b00, s_f} < used) && cfg.io_enable && waiting_reg[sidx]
                     && (byte0 == cfg.io_base_address + {6'b000000, s_f});
        end
    end

    assign frame_wr = acc && (op == OP_BYTE) && (pos_reg < PW'(FRAME_BYTES));

    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        end_next     = end_reg;
        phase_next   = phase_reg;
        waiting_next = waiting_reg;
        miss_next    = miss_reg;
        faulted_next = faulted_reg;
        pos_next     = pos_reg;
        rxch_next    = rxch_reg;
        busy_next    = busy_reg;
        push         = 1'b0;
        cmd          = '0;

        if (frame_done)
        begin
            busy_next = 1'b0;
        end

        unique case (state_reg)
            F_IDLE:
            begin
                if (acc && (op == OP_TICK))
                begin
                    phase_next = (phase_inc >= {1'b0, period}) ? 8'd0 : phase_inc[7:0];
                    if ((phase_reg == '0) && (cfg.ats_enable || has_io))
                    begin
                        state_next = F_POLL;
                        slot_next  = cfg.ats_enable ? '0 : SW'(1);
                        end_next   = has_io ? SW'(used) : '0;
                    end
                end
                else if (acc)
                begin
                    if (pos_reg == '0)
                    begin
                        rxch_next = in_ch;
                    end
                    if (pos_reg < PW'(FRAME_BYTES))
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        pos_next = '0;
                        if (fvalid)
                        begin
                            push               = 1'b1;
                            cmd.is_frame       = 1'b1;
                            cmd.is_ats         = (ch_f == 2'd0);
                            cmd.last           = 1'b1;
                            cmd.ch             = ch_f;
                            waiting_next[sidx] = 1'b0;
                            miss_next[sidx]    = '0;
                            faulted_next[sidx] = 1'b0;
                            busy_next          = 1'b1;
                        end
                    end
                end
            end
            F_POLL:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    cmd.is_ats = (slot_reg == '0);
                    cmd.last   = (slot_reg == end_reg);
                    cmd.ch     = 2'(slot_reg);
                    cmd.addr   = (slot_reg == '0) ? cfg.ats_address
                                 : cfg.io_base_address + 8'(slot_reg) - 8'd1;
                    if (waiting_reg[sidx])
                    begin
                        if (miss_reg[sidx] >= cfg.miss_limit)
                        begin
                            if (!faulted_reg[sidx])
                            begin
                                cmd.report         = 1'b1;
                                faulted_next[sidx] = 1'b1;
                            end
                        end
                        else
                        begin
                            miss_next[sidx] = miss_reg[sidx] + 4'd1;
                        end
                    end
                    waiting_next[sidx] = 1'b1;
                    if (slot_reg == end_reg)
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            slot_reg  <= '0;
            end_reg   <= '0;
            phase_reg <= '0;
            pos_reg   <= '0;
            rxch_reg  <= '0;
            busy_reg  <= 1'b0;
            for (int i = 0; i < NS; i++)
            begin
                waiting_reg[i] <= 1'b0;
                miss_reg[i]    <= '0;
                faulted_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            end_reg     <= end_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            rxch_reg    <= rxch_next;
            busy_reg    <= busy_next;
            waiting_reg <= waiting_next;
            miss_reg    <= miss_next;
            faulted_reg <= faulted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_wr)
        begin
            frame_reg[pos_reg[FI-1:0]] <= s_tdata;
        end
    end

    assign frame = frame_reg;

endmodule

`default_nettype wire

// File: rtl/mpmlm_back.sv
`default_nettype none

module mpmlm_back #(
    parameter int ATS_WORDS   = 8,
    parameter int IO_BYTES    = 4,
    parameter int FRAME_BYTES = 19
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    input  mpmlm_pkg::cmd_t     cmd,
    output logic                pop,
    input  wire  [7:0]          frame [FRAME_BYTES],
    output logic                frame_done,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [23:0]         m_tdata,
    output logic [3:0]          m_tuser,
    output logic                m_tlast
);
    import mpmlm_pkg::*;

    localparam int MAXN = (ATS_WORDS > IO_BYTES) ? ((ATS_WORDS > 8) ? ATS_WORDS : 8)
                                                 : ((IO_BYTES > 8) ? IO_BYTES : 8);
    localparam int CW = $clog2(MAXN);
    localparam int NV = 2 ** CW;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_VAL   = 4'b0010,
        B_STAT  = 4'b0100,
        B_REQ   = 4'b1000
    } bstate_t;

    bstate_t        state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [15:0]    crc_reg, crc_next;
    logic           valid_reg, valid_next;
    logic [1:0]     kind_reg, kind_next;
    logic [1:0]     och_reg, och_next;
    logic [2:0]     idx_reg, idx_next;
    logic [15:0]    data_reg, data_next;
    logic           fault_reg, fault_next;
    logic           last_reg, last_next;

    logic [15:0]    ats_word [NV];
    logic [7:0]     io_val [NV];
    logic           out_free;
    logic [CW-1:0]  n_last;
    logic [7:0]     req_byte;

    for (genvar i = 0; i < NV; i++)
    begin : g_words
        localparam int HI = 3 + 2 * i;
        localparam int LO = 4 + 2 * i;
        localparam int IB = 3 + i;
        if (i < ATS_WORDS && HI < FRAME_BYTES)
        begin : g_hi
            assign ats_word[i][15:8] = frame[HI];
        end
        else
        begin : g_hi0
            assign ats_word[i][15:8] = 8'h00;
        end
        if (i < ATS_WORDS && LO < FRAME_BYTES)
        begin : g_lo
            assign ats_word[i][7:0] = frame[LO];
        end
        else
        begin : g_lo0
            assign ats_word[i][7:0] = 8'h00;
        end
        if (i < IO_BYTES && IB < FRAME_BYTES)
        begin : g_io
            assign io_val[i] = frame[IB];
        end
        else
        begin : g_io0
            assign io_val[i] = 8'h00;
        end
    end

    assign out_free = !valid_reg || m_tready;
    assign n_last   = cmd_reg.is_ats ? CW'(ATS_WORDS - 1) : CW'(IO_BYTES - 1);

    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0: req_byte = cmd_reg.addr;
            3'd1: req_byte = cmd_reg.is_ats ? FUNC_READ_HOLDING : FUNC_READ_INPUTS;
            3'd2: req_byte = 8'h00;
            3'd3: req_byte = 8'h00;
            3'd4: req_byte = 8'h00;
            3'd5: req_byte = cmd_reg.is_ats ? 8'(ATS_WORDS) : 8'(IO_BYTES * 8);
            3'd6: req_byte = crc_reg[15:8];
            3'd7: req_byte = crc_reg[7:0];
            default: req_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        kind_next  = kind_reg;
        och_next   = och_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        fault_next = fault_reg;
        last_next  = last_reg;
        valid_next = m_tready ? 1'b0 : valid_reg;
        pop        = 1'b0;
        frame_done = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = cmd;
                    cnt_next = '0;
                    crc_next = 16'hFFFF;
                    state_next = (cmd.is_frame || cmd.report) ? B_VAL : B_REQ;
                end
            end
            B_VAL:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_VALUE;
                    och_next   = cmd_reg.ch;
                    idx_next   = cnt_reg[2:0];
                    fault_next = 1'b0;
                    last_next  = 1'b0;
                    if (!cmd_reg.is_frame)
                    begin
                        data_next = 16'h0000;
                    end
                    else if (cmd_reg.is_ats)
                    begin
                        data_next = ats_word[cnt_reg];
                    end
                    else
                    begin
                        data_next = {8'h00, io_val[cnt_reg]};
                    end
                    if (cnt_reg == n_last)
                    begin
                        state_next = B_STAT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            B_STAT:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_STATUS;
                    och_next   = cmd_reg.ch;
                    idx_next   = '0;
                    data_next  = 16'h0000;
                    fault_next = !cmd_reg.is_frame;
                    last_next  = cmd_reg.is_frame;
                    cnt_next   = '0;
                    if (cmd_reg.is_frame)
                    begin
                        frame_done = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_REQ;
                    end
                end
            end
            B_REQ:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    kind_next  = KIND_TX;
                    och_next   = cmd_reg.ch;
                    idx_next   = cnt_reg[2:0];
                    data_next  = {8'h00, req_byte};
                    fault_next = 1'b0;
                    last_next  = cmd_reg.last && (cnt_reg[2:0] == 3'd7);
                    if (cnt_reg[2:0] < 3'd6)
                    begin
                        crc_next = crc16_byte(crc_reg, req_byte);
                    end
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        cnt_reg   <= cnt_next;
        crc_reg   <= crc_next;
        kind_reg  <= kind_next;
        och_reg   <= och_next;
        idx_reg   <= idx_next;
        data_reg  <= data_next;
        fault_reg <= fault_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'h0, fault_reg, data_reg, idx_reg};
    assign m_tuser  = {och_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: rtl/modbus_poll_master_link_monitor.sv
// Modbus polling master with link monitoring for one transfer-switch slave
// and up to IO_SLAVES input slaves.
// Input stream (s_*): each beat is a time tick or one received response byte.
// A poll round runs on the first tick after reset and every poll_period ticks;
// each enabled slave then gets an 8-byte read request on the output stream.
// Received bytes are gathered into a frame; a frame from a waiting slave with a
// matching address gives value updates and a fault status with fault clear.
// Output stream (m_*): transmit bytes, value updates and fault status beats,
// tlast marking the final beat caused by one input beat.
// Throughput: a received byte is taken every cycle while the front part is idle
// and the command queue has room, except that while a frame's values are still
// being sent no further input beat is taken. A polling tick starts a pass in the
// front part that queues one command per polled slave, taking no input meanwhile.
// The back part sends one beat a cycle unless the receiver stalls, passing its idle
// state between slave commands, folding the first six request bytes into the CRC.
// A four-entry command queue lets input beats be taken while output stalls;
// when it fills, s_tready drops until the receiver takes beats again.
// Reset (rst_n, asynchronous) clears all slave state, the tick phase and the
// frame position, and loads the configuration defaults. No clearing pass.
`default_nettype none

module modbus_poll_master_link_monitor #(
    parameter int IO_SLAVES   = mpmlm_pkg::IO_SLAVES_DEF,
    parameter int ATS_WORDS   = mpmlm_pkg::ATS_WORDS_DEF,
    parameter int IO_BYTES    = mpmlm_pkg::IO_BYTES_DEF,
    parameter int FRAME_BYTES = mpmlm_pkg::FRAME_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [7:0]  cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // rx_byte
    input  wire  [2:0]  s_tuser,    // operation [0], channel [2:1]
    input  wire         s_tlast,    // frame_end
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,    // index [2:0], data [18:3], fault [19], zero [23:20]
    output logic [3:0]  m_tuser,    // kind [1:0], out_channel [3:2]
    output logic        m_tlast     // last
);
    import mpmlm_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   push;
    cmd_t   cmd_in;
    cmd_t   cmd_out;
    logic   full;
    logic   not_empty;
    logic   pop;
    logic   frame_done;
    logic [7:0] frame [FRAME_BYTES];

    // Configuration writes land straight in the register file.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ATS_ENABLE:  cfg_next.ats_enable      = cfg_data[0];
                REG_IO_ENABLE:   cfg_next.io_enable       = cfg_data[0];
                REG_MODULE_CNT:  cfg_next.module_count    = cfg_data[1:0];
                REG_ATS_ADDRESS: cfg_next.ats_address     = cfg_data;
                REG_IO_BASE:     cfg_next.io_base_address = cfg_data;
                REG_MISS_LIMIT:  cfg_next.miss_limit      = cfg_data[3:0];
                REG_POLL_PERIOD: cfg_next.poll_period     = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ats_enable      <= 1'b0;
            cfg_reg.io_enable       <= 1'b0;
            cfg_reg.module_count    <= 2'd0;
            cfg_reg.ats_address     <= 8'd1;
            cfg_reg.io_base_address <= 8'd2;
            cfg_reg.miss_limit      <= 4'd5;
            cfg_reg.poll_period     <= 8'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: takes input beats, keeps the link state, issues commands.
    mpmlm_front #(
        .IO_SLAVES   (IO_SLAVES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push       (push),
        .cmd        (cmd_in),
        .full       (full),
        .frame_done (frame_done),
        .frame      (frame)
    );

    mpmlm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (cmd_in),
        .full      (full),
        .pop       (pop),
        .dout      (cmd_out),
        .not_empty (not_empty)
    );

    // Back: expands each command into output beats.
    mpmlm_back #(
        .ATS_WORDS   (ATS_WORDS),
        .IO_BYTES    (IO_BYTES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (not_empty),
        .cmd        (cmd_out),
        .pop        (pop),
        .frame      (frame),
        .frame_done (frame_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/mpmlm_checker.sv
`default_nettype none

module mpmlm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire [3:0]  m_tuser,
    input wire        m_tlast
);
    import mpmlm_pkg::*;

    // A stalled beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat withdrawn while stalled");

    // The final beat of an item is a request byte or a status beat.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser[1:0] == KIND_TX) || (m_tuser[1:0] == KIND_STATUS))
        else $error("value update marked as last beat");

    // The fault flag is only set on status beats.
    a_fault_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19] |-> (m_tuser[1:0] == KIND_STATUS))
        else $error("fault flag outside a status beat");

    // A status beat with fault clear always closes its item.
    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == KIND_STATUS) && !m_tdata[19] |-> m_tlast)
        else $error("frame status beat not last");

endmodule

bind modbus_poll_master_link_monitor mpmlm_checker u_mpmlm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
